// ===== rtl/murmur_pkg.sv =====
// types, constants and helper functions shared by the murmur64a hash block
`default_nettype none

package murmur_pkg;

  localparam logic [63:0] MulM      = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MulLo     = MulM[31:0];
  localparam logic [31:0] MulHi     = MulM[63:32];
  localparam int unsigned MixShift  = 47;
  localparam logic [31:0] SeedReset = 32'h41C64E6D;

  localparam int unsigned InTdataW  = 104;
  localparam int unsigned OutTdataW = 64;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_START = 10'b00_0000_0010,
    S_BODY  = 10'b00_0000_0100,
    S_MUL0  = 10'b00_0000_1000,
    S_MUL1  = 10'b00_0001_0000,
    S_MUL2  = 10'b00_0010_0000,
    S_MUL3  = 10'b00_0100_0000,
    S_NEXT  = 10'b00_1000_0000,
    S_FIN   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_BLK1,
    OP_BLK2,
    OP_BLK3,
    OP_TAIL,
    OP_AVAL
  } op_e;

  typedef enum logic [2:0] {
    XS_LEN,
    XS_WORD,
    XS_ACC_MIX,
    XS_H_ACC,
    XS_TAIL,
    XS_H_MIX
  } x_sel_e;

  typedef enum logic [1:0] {
    HS_SEED_ACC,
    HS_ACC,
    HS_ACC_MIX
  } h_sel_e;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_P0,
    MS_P1,
    MS_P2,
    MS_P3
  } mul_step_e;

  typedef struct packed {
    logic      item_load;
    logic      x_load;
    x_sel_e    x_sel;
    logic      h_load;
    h_sel_e    h_sel;
    mul_step_e mul_step;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full_word;
    logic has_tail;
  } sts_t;

  function automatic logic [63:0] mix47(input logic [63:0] v);
    mix47 = v ^ (v >> MixShift);
  endfunction

  function automatic logic [63:0] tail_mask(input logic [2:0] n);
    tail_mask = (64'h1 << {n, 3'b000}) - 64'h1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/murmur_dp.sv =====
// datapath: item latch, seed, running hash and the shared 32x32 multiplier
`default_nettype none

module murmur_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic [63:0]          word_i,
  input  wire logic [3:0]           nbytes_i,
  input  wire logic                 first_i,
  input  wire logic [31:0]          len_i,
  input  wire logic                 last_i,
  input  wire murmur_pkg::cmd_t     cmd_i,
  output murmur_pkg::sts_t          sts_o,
  output logic [63:0]               hash_o
);

  logic [63:0] word_q;
  logic [3:0]  nb_q;
  logic        first_q;
  logic [31:0] len_q;
  logic        last_q;
  logic [31:0] seed_q;
  logic [63:0] h_q, h_d;
  logic [63:0] x_q, x_d;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [63:0] hash_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      word_q  <= word_i;
      nb_q    <= nbytes_i;
      first_q <= first_i;
      len_q   <= len_i;
      last_q  <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= murmur_pkg::SeedReset;
    end else if (cfg_we_i) begin
      seed_q <= cfg_data_i;
    end
  end

  always_comb begin
    case (cmd_i.x_sel)
      murmur_pkg::XS_LEN:     x_d = {32'b0, len_q};
      murmur_pkg::XS_WORD:    x_d = word_q;
      murmur_pkg::XS_ACC_MIX: x_d = murmur_pkg::mix47(acc_q);
      murmur_pkg::XS_H_ACC:   x_d = h_q ^ acc_q;
      murmur_pkg::XS_TAIL:    x_d = h_q ^ (word_q & murmur_pkg::tail_mask(nb_q[2:0]));
      murmur_pkg::XS_H_MIX:   x_d = murmur_pkg::mix47(h_q);
      default:                x_d = word_q;
    endcase
  end

  always_comb begin
    case (cmd_i.h_sel)
      murmur_pkg::HS_SEED_ACC: h_d = {32'b0, seed_q} ^ acc_q;
      murmur_pkg::HS_ACC:      h_d = acc_q;
      murmur_pkg::HS_ACC_MIX:  h_d = murmur_pkg::mix47(acc_q);
      default:                 h_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
    end else if (cmd_i.h_load) begin
      h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.x_load) begin
      x_q <= x_d;
    end
  end

  // low 64 bits of x * m from three 32x32 partial products
  assign mul_a = (cmd_i.mul_step == murmur_pkg::MS_P2) ? x_q[63:32] : x_q[31:0];
  assign mul_b = (cmd_i.mul_step == murmur_pkg::MS_P1) ? murmur_pkg::MulHi
                                                         : murmur_pkg::MulLo;
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  always_ff @(posedge clk_i) begin
    case (cmd_i.mul_step)
      murmur_pkg::MS_P0: begin
        prod_q <= mul_p;
      end
      murmur_pkg::MS_P1: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      murmur_pkg::MS_P2: begin
        acc_q  <= acc_q + {prod_q[31:0], 32'b0};
        prod_q <= mul_p;
      end
      murmur_pkg::MS_P3: begin
        acc_q  <= acc_q + {prod_q[31:0], 32'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      hash_q <= h_q;
    end
  end

  assign sts_o.first     = first_q;
  assign sts_o.last      = last_q;
  assign sts_o.full_word = nb_q[3];
  assign sts_o.has_tail  = |nb_q[2:0];
  assign hash_o          = hash_q;

endmodule

`default_nettype wire

// ===== rtl/murmur_ctrl.sv =====
// controller: sequences initialisation, block mixing, tail and avalanche
`default_nettype none

module murmur_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire murmur_pkg::sts_t  sts_i,
  output murmur_pkg::cmd_t       cmd_o
);

  murmur_pkg::state_e state_q, state_d;
  murmur_pkg::op_e    op_q, op_d;
  logic               in_msg_q, in_msg_d;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= murmur_pkg::S_IDLE;
      op_q        <= murmur_pkg::OP_INIT;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    in_msg_d       = in_msg_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    in_ready_o     = 1'b0;
    cmd_o.item_load = 1'b0;
    cmd_o.x_load   = 1'b0;
    cmd_o.x_sel    = murmur_pkg::XS_LEN;
    cmd_o.h_load   = 1'b0;
    cmd_o.h_sel    = murmur_pkg::HS_ACC;
    cmd_o.mul_step = murmur_pkg::MS_NONE;
    cmd_o.out_load = 1'b0;

    case (state_q)
      murmur_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = murmur_pkg::S_START;
        end
      end
      murmur_pkg::S_START: begin
        if (sts_i.first) begin
          cmd_o.x_load = 1'b1;
          cmd_o.x_sel  = murmur_pkg::XS_LEN;
          op_d         = murmur_pkg::OP_INIT;
          state_d      = murmur_pkg::S_MUL0;
        end else if (in_msg_q) begin
          state_d = murmur_pkg::S_BODY;
        end else begin
          state_d = murmur_pkg::S_IDLE;
        end
      end
      murmur_pkg::S_BODY: begin
        if (!sts_i.last || sts_i.full_word) begin
          cmd_o.x_load = 1'b1;
          cmd_o.x_sel  = murmur_pkg::XS_WORD;
          op_d         = murmur_pkg::OP_BLK1;
          state_d      = murmur_pkg::S_MUL0;
        end else if (sts_i.has_tail) begin
          cmd_o.x_load = 1'b1;
          cmd_o.x_sel  = murmur_pkg::XS_TAIL;
          op_d         = murmur_pkg::OP_TAIL;
          state_d      = murmur_pkg::S_MUL0;
        end else begin
          state_d = murmur_pkg::S_FIN;
        end
      end
      murmur_pkg::S_MUL0: begin
        cmd_o.mul_step = murmur_pkg::MS_P0;
        state_d        = murmur_pkg::S_MUL1;
      end
      murmur_pkg::S_MUL1: begin
        cmd_o.mul_step = murmur_pkg::MS_P1;
        state_d        = murmur_pkg::S_MUL2;
      end
      murmur_pkg::S_MUL2: begin
        cmd_o.mul_step = murmur_pkg::MS_P2;
        state_d        = murmur_pkg::S_MUL3;
      end
      murmur_pkg::S_MUL3: begin
        cmd_o.mul_step = murmur_pkg::MS_P3;
        state_d        = murmur_pkg::S_NEXT;
      end
      murmur_pkg::S_NEXT: begin
        case (op_q)
          murmur_pkg::OP_INIT: begin
            cmd_o.h_load = 1'b1;
            cmd_o.h_sel  = murmur_pkg::HS_SEED_ACC;
            in_msg_d     = 1'b1;
            state_d      = murmur_pkg::S_BODY;
          end
          murmur_pkg::OP_BLK1: begin
            cmd_o.x_load = 1'b1;
            cmd_o.x_sel  = murmur_pkg::XS_ACC_MIX;
            op_d         = murmur_pkg::OP_BLK2;
            state_d      = murmur_pkg::S_MUL0;
          end
          murmur_pkg::OP_BLK2: begin
            cmd_o.x_load = 1'b1;
            cmd_o.x_sel  = murmur_pkg::XS_H_ACC;
            op_d         = murmur_pkg::OP_BLK3;
            state_d      = murmur_pkg::S_MUL0;
          end
          murmur_pkg::OP_BLK3: begin
            cmd_o.h_load = 1'b1;
            cmd_o.h_sel  = murmur_pkg::HS_ACC;
            state_d      = sts_i.last ? murmur_pkg::S_FIN : murmur_pkg::S_IDLE;
          end
          murmur_pkg::OP_TAIL: begin
            cmd_o.h_load = 1'b1;
            cmd_o.h_sel  = murmur_pkg::HS_ACC;
            state_d      = murmur_pkg::S_FIN;
          end
          murmur_pkg::OP_AVAL: begin
            cmd_o.h_load = 1'b1;
            cmd_o.h_sel  = murmur_pkg::HS_ACC_MIX;
            in_msg_d     = 1'b0;
            state_d      = murmur_pkg::S_OUT;
          end
          default: begin
            state_d = murmur_pkg::S_IDLE;
          end
        endcase
      end
      murmur_pkg::S_FIN: begin
        cmd_o.x_load = 1'b1;
        cmd_o.x_sel  = murmur_pkg::XS_H_MIX;
        op_d         = murmur_pkg::OP_AVAL;
        state_d      = murmur_pkg::S_MUL0;
      end
      murmur_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = murmur_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = murmur_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == murmur_pkg::S_START))
    else $error("accepted item did not start processing");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_msg_ends_on_avalanche: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_msg_q) |-> ($past(state_q == murmur_pkg::S_NEXT)
                         && $past(op_q == murmur_pkg::OP_AVAL)))
    else $error("message closed without avalanche");

endmodule

`default_nettype wire

// ===== rtl/murmur64a_hash.sv =====
// top level of the streaming murmurhash64a block
//
// input stream: one item per 64-bit message word, little-endian bytes. tuser marks
// the first item (which carries total_length), tlast the final one; valid_bytes
// counts the bytes of the final word (0 to 8, larger values count as 8).
// output stream: one item with the 64-bit hash after each message's final item.
// seed is written through cfg_valid_i/cfg_data_i; the user does so only while the
// block is idle, which the block itself does not enforce. all 64-bit products run
// on one shared 32x32 multiplier, stepping through S_MUL0 to S_MUL3 for each, so
// that multiplier sets the rate: a word inside a message takes three products,
// the first item adds one for the initial value and the final item adds one for
// the avalanche and the output load; a final item with a tail of one to seven
// bytes takes one product instead of three. an item outside a message is dropped.
// the finished hash waits in an output register, and a new item is taken
// meanwhile; only a second result stalls until the first has been taken.
// reset clears the running hash and message flag and loads the seed with
// its reset value; no clearing pass is needed.
`default_nettype none

module murmur64a_hash (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [31:0]                           cfg_data_i,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // data_word [63:0], valid_bytes [67:64], total_length [99:68], zero pad
  input  wire logic [murmur_pkg::InTdataW-1:0]       s_axis_tdata,
  // first [0]
  input  wire logic                                  s_axis_tuser,
  input  wire logic                                  s_axis_tlast,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // hash_value [63:0]
  output logic [murmur_pkg::OutTdataW-1:0]           m_axis_tdata
);

  murmur_pkg::cmd_t cmd;
  murmur_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  murmur_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  murmur_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .word_i     (s_axis_tdata[63:0]),
    .nbytes_i   (s_axis_tdata[67:64]),
    .first_i    (s_axis_tuser),
    .len_i      (s_axis_tdata[99:68]),
    .last_i     (s_axis_tlast),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .hash_o     (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/murmur64a_hash_checker.sv =====
`timescale 1ns / 1ps
// checker for the murmurhash64a block: watches the streams, predicts each hash and compares
module murmur64a_hash_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  input  wire logic                               cfg_ready_i,
  input  wire logic [31:0]                        cfg_data_i,
  input  wire logic                               s_tvalid_i,
  input  wire logic                               s_tready_i,
  // data_word [63:0], valid_bytes [67:64], total_length [99:68], zero pad
  input  wire logic [murmur_pkg::InTdataW-1:0]    s_tdata_i,
  // first [0]
  input  wire logic                               s_tuser_i,
  input  wire logic                               s_tlast_i,
  input  wire logic                               m_tvalid_i,
  input  wire logic                               m_tready_i,
  // hash_value [63:0]
  input  wire logic [murmur_pkg::OutTdataW-1:0]   m_tdata_i,
  output int unsigned                             pending_o,
  output int unsigned                             mismatches_o
);

  localparam logic [63:0] HashMul   = 64'hc6a4a7935bd1e995;
  localparam int unsigned HashShift = 47;
  localparam logic [31:0] SeedInit  = 32'h41C64E6D;

  logic [31:0] seed;
  logic [63:0] running_hash;
  logic        in_msg;
  logic [63:0] expected_hashes[$];
  logic [63:0] want;
  int unsigned mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  function automatic logic [63:0] mix_word(input logic [63:0] h, input logic [63:0] w);
    logic [63:0] k;
    k = w * HashMul;
    k = k ^ (k >> HashShift);
    k = k * HashMul;
    return (h ^ k) * HashMul;
  endfunction

  function automatic logic [63:0] finish_hash(input logic [63:0] h);
    logic [63:0] v;
    v = h ^ (h >> HashShift);
    v = v * HashMul;
    return v ^ (v >> HashShift);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns  hash check: %s", $time, what);
  endtask

  task automatic absorb_item(input logic [63:0] word, input logic [3:0] nbytes,
                             input logic first, input logic [31:0] len, input logic last);
    logic [63:0] h;
    logic [3:0]  n;
    if (first) begin
      running_hash = {32'h0, seed} ^ ({32'h0, len} * HashMul);
      in_msg = 1'b1;
    end else if (!in_msg) begin
      return;
    end
    h = running_hash;
    if (!last) begin
      running_hash = mix_word(h, word);
      return;
    end
    n = (nbytes > 4'd8) ? 4'd8 : nbytes;
    if (n == 4'd8) begin
      h = mix_word(h, word);
    end else if (n != 4'd0) begin
      h = (h ^ (word & ((64'h1 << (n * 8)) - 64'h1))) * HashMul;
    end
    h = finish_hash(h);
    running_hash = h;
    in_msg = 1'b0;
    expected_hashes.push_back(h);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed = SeedInit;
      running_hash = '0;
      in_msg = 1'b0;
      expected_hashes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        seed = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        absorb_item(s_tdata_i[63:0], s_tdata_i[67:64], s_tuser_i, s_tdata_i[99:68], s_tlast_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch($sformatf("hash %h with no message finished", m_tdata_i));
        end else begin
          want = expected_hashes.pop_front();
          if (m_tdata_i !== want) begin
            report_mismatch($sformatf("hash_value %h, predicted %h", m_tdata_i, want));
          end
        end
      end
    end
    pending_o <= expected_hashes.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench top for the murmurhash64a block: stimulus, flow control and verdict
module tb;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              cfg_valid_i   = 1'b0;
  logic                              cfg_ready_o;
  logic [31:0]                       cfg_data_i    = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [murmur_pkg::InTdataW-1:0]   s_axis_tdata  = '0;
  logic                              s_axis_tuser  = 1'b0;
  logic                              s_axis_tlast  = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [murmur_pkg::OutTdataW-1:0]  m_axis_tdata;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 65;
  int unsigned msg_items     = 0;
  int unsigned hold_left     = 0;
  int unsigned hold_reqs     = 0;
  int unsigned hold_seen     = 0;

  murmur64a_hash i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  murmur64a_hash_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [63:0] word, input logic [3:0] nbytes,
                           input logic first, input logic [31:0] len, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, len, nbytes, word};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // body words then an optional last item; unfinished messages are left open
  task automatic send_msg(input int unsigned body, input logic [3:0] tail,
                          input bit finish, input bit odd_len);
    logic [31:0] len;
    int unsigned count;
    logic        is_last;
    len   = odd_len ? 32'($urandom) : 32'(body * 8 + ((tail > 4'd8) ? 8 : tail));
    count = finish ? body + 1 : body;
    for (int unsigned i = 0; i < count; i++) begin
      is_last = finish && (i == body);
      send_item({$urandom, $urandom}, is_last ? tail : 4'($urandom), i == 0,
                (i == 0) ? len : 32'($urandom), is_last);
    end
    msg_items += count;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (48) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned items_goal, input bit with_hold);
    int unsigned start;
    int unsigned roll;
    int unsigned body;
    logic [3:0]  tail;
    bit          hold_done;
    start     = msg_items;
    hold_done = 1'b0;
    while (msg_items - start < items_goal) begin
      if (with_hold && !hold_done && (msg_items - start > items_goal / 2)) begin
        hold_done = 1'b1;
        hold_reqs++;
        repeat (8) send_msg(0, 4'($urandom_range(0, 15)), 1'b1, 1'b0);
        drain_results();
      end
      roll = $urandom_range(99);
      body = ($urandom_range(9) < 6) ? $urandom_range(0, 3) : $urandom_range(4, 12);
      tail = ($urandom_range(9) < 7) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      if (roll < 8) begin
        // stray item without a first flag
        send_item({$urandom, $urandom}, 4'($urandom), 1'b0, 32'($urandom), 1'($urandom));
      end else if (roll < 14) begin
        send_msg($urandom_range(1, 4), 4'd0, 1'b0, 1'b0);
      end else begin
        send_msg(body, tail, 1'b1, $urandom_range(99) < 15);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with the reset seed
    send_item('1, 4'd8, 1'b0, '1, 1'b1);
    send_item('1, 4'd0, 1'b1, 32'd0, 1'b1);
    send_item('1, 4'd8, 1'b1, '1, 1'b1);
    send_item('0, 4'd15, 1'b1, 32'd8, 1'b1);
    send_item({$urandom, $urandom}, 4'd9, 1'b1, 32'd8, 1'b1);
    send_item('1, 4'd8, 1'b1, 32'd11, 1'b0);
    send_item('1, 4'd3, 1'b0, 32'd0, 1'b1);
    // restart inside a message
    send_item({$urandom, $urandom}, 4'd8, 1'b1, 32'd16, 1'b0);
    send_item({$urandom, $urandom}, 4'd8, 1'b1, 32'd24, 1'b0);
    send_item({$urandom, $urandom}, 4'd8, 1'b0, 32'd0, 1'b0);
    send_item({$urandom, $urandom}, 4'd7, 1'b0, 32'd0, 1'b1);
    send_item({$urandom, $urandom}, 4'd5, 1'b1, 32'd1234, 1'b1);
    for (int n = 1; n < 8; n++) begin
      send_item({$urandom, $urandom}, 4'(n), 1'b1, 32'(n), 1'b1);
    end
    send_item({$urandom, $urandom}, 4'd1, 1'b0, 32'd1, 1'b1);
    drain_results();

    write_seed(32'h0000_0000);
    random_phase(480, 1'b1);
    drain_results();

    send_idle_pct = 65;
    recv_idle_pct = 35;
    write_seed(32'hFFFF_FFFF);
    random_phase(480, 1'b0);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_seed(32'($urandom));
    random_phase(480, 1'b0);
    drain_results();

    if (mismatches == 0) begin
      $display("murmur64a_hash verification clean");
    end else begin
      $display("murmur64a_hash verification failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("murmur64a_hash verification failed");
    $finish;
  end

endmodule
